/* rtl/lap3_pkg.sv */
// ----------------------------------------------------------------------------
// lap3_pkg
// Shared constants and types of the 3x3 Laplacian convolution core.
// ----------------------------------------------------------------------------
package lap3_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int PIX_W      = 8;
   localparam int POS_W      = 12;
   localparam int CFG_W      = 13;
   localparam int SUM3_W     = PIX_W + 2;

   localparam logic [CFG_W-1:0] MIN_SIZE       = CFG_W'(3);
   localparam logic [CFG_W-1:0] MAX_WIDTH_VAL  = CFG_W'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] MAX_HEIGHT_VAL = CFG_W'(MAX_HEIGHT);
   localparam logic [CFG_W-1:0] WIDTH_RESET    = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET   = CFG_W'(480);

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel;
      logic [ADDR_W-1:0] col;
      logic [POS_W-1:0]  out_row;
      logic [POS_W-1:0]  out_col;
      logic              produce;
      logic              last;
   } stage_type;

endpackage

/* rtl/laplacian_3x3_convolution_core.sv */
// ----------------------------------------------------------------------------
// laplacian_3x3_convolution_core
// Streaming 3x3 Laplacian filter over raster-order grayscale pixels.
// The pixel that completes a window is registered in stage one, and its
// result is registered in the result stage and held while the output stalls.
// Throughput: one pixel per cycle; each line store takes one read and one
// write per cycle, and the input stalls only while a result waits on the
// output. Reset clears the counters, the window and the size registers
// (640 x 480); the line stores are not cleared.
// ----------------------------------------------------------------------------
module laplacian_3x3_convolution_core
   import lap3_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             req_frame_start,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_filtered_value,
   output logic [POS_W-1:0] rsp_out_row,
   output logic [POS_W-1:0] rsp_out_col,
   output logic             rsp_frame_last,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [CFG_W-1:0] eff_w;
   logic [CFG_W-1:0] eff_h;

   logic [POS_W-1:0] col_ff;
   logic [POS_W-1:0] col_in;
   logic [POS_W-1:0] row_ff;
   logic [POS_W-1:0] row_in;

   logic             s1_valid_ff;
   stage_type        s1_ff;
   stage_type        s1_in;
   logic             fwd_ff;
   logic [PIX_W-1:0] fwd_up_ff;
   logic [PIX_W-1:0] fwd_mid_ff;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_value_ff;
   logic [POS_W-1:0] rsp_row_ff;
   logic [POS_W-1:0] rsp_col_ff;
   logic             rsp_last_ff;

   logic             accept;
   logic             s1_done;
   logic [CFG_W-1:0] c0;
   logic [CFG_W-1:0] r0;
   logic [CFG_W-1:0] c1;
   logic [CFG_W-1:0] r1;
   logic [CFG_W-1:0] r2;
   logic [CFG_W-1:0] cn;
   logic [CFG_W-1:0] rn;

   logic [PIX_W-1:0]      ram_up;
   logic [PIX_W-1:0]      ram_mid;
   logic [PIX_W-1:0]      up_px;
   logic [PIX_W-1:0]      mid_px;
   logic signed [POS_W:0] row_up;
   logic signed [POS_W:0] row_mid;
   logic signed [POS_W:0] row_low;
   logic signed [POS_W:0] lap;
   logic [PIX_W-1:0]      lap_clamped;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      if (width_ff < MIN_SIZE) begin
         eff_w = MIN_SIZE;
      end else if (width_ff > MAX_WIDTH_VAL) begin
         eff_w = MAX_WIDTH_VAL;
      end else begin
         eff_w = width_ff;
      end
      if (height_ff < MIN_SIZE) begin
         eff_h = MIN_SIZE;
      end else if (height_ff > MAX_HEIGHT_VAL) begin
         eff_h = MAX_HEIGHT_VAL;
      end else begin
         eff_h = height_ff;
      end
   end

   assign s1_done   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_done;
   assign accept    = req_valid && req_ready;

   always_comb begin
      c0 = req_frame_start ? '0 : CFG_W'(col_ff);
      r0 = req_frame_start ? '0 : CFG_W'(row_ff);
      if (c0 >= eff_w) begin
         c1 = '0;
         r1 = r0 + CFG_W'(1);
      end else begin
         c1 = c0;
         r1 = r0;
      end
      r2 = (r1 >= eff_h) ? '0 : r1;
      cn = c1 + CFG_W'(1);
      rn = r2;
      if (cn >= eff_w) begin
         cn = '0;
         rn = r2 + CFG_W'(1);
         if (rn >= eff_h) begin
            rn = '0;
         end
      end
      col_in = cn[POS_W-1:0];
      row_in = rn[POS_W-1:0];

      s1_in.pixel   = req_pixel;
      s1_in.col     = c1[ADDR_W-1:0];
      s1_in.out_row = r2[POS_W-1:0] - POS_W'(1);
      s1_in.out_col = c1[POS_W-1:0] - POS_W'(1);
      s1_in.produce = (r2 >= CFG_W'(2)) && (c1 >= CFG_W'(2));
      s1_in.last    = (r2 == eff_h - CFG_W'(1)) && (c1 == eff_w - CFG_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (accept) begin
            col_ff      <= col_in;
            row_ff      <= row_in;
            s1_valid_ff <= 1'b1;
            fwd_ff      <= s1_done && (s1_ff.col == s1_in.col);
         end else if (s1_done) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff      <= s1_in;
         fwd_up_ff  <= mid_px;
         fwd_mid_ff <= s1_ff.pixel;
      end
   end

   lap3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_upper (
      .clock   (clock),
      .wr_en   (s1_done),
      .wr_addr (s1_ff.col),
      .wr_data (mid_px),
      .rd_en   (accept),
      .rd_addr (s1_in.col),
      .rd_data (ram_up)
   );

   lap3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_middle (
      .clock   (clock),
      .wr_en   (s1_done),
      .wr_addr (s1_ff.col),
      .wr_data (s1_ff.pixel),
      .rd_en   (accept),
      .rd_addr (s1_in.col),
      .rd_data (ram_mid)
   );

   assign up_px  = fwd_ff ? fwd_up_ff  : ram_up;
   assign mid_px = fwd_ff ? fwd_mid_ff : ram_mid;

   lap3_cell u_cell_upper (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (s1_done),
      .center_row (1'b0),
      .tap_in     (up_px),
      .row_sum    (row_up)
   );

   lap3_cell u_cell_middle (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (s1_done),
      .center_row (1'b1),
      .tap_in     (mid_px),
      .row_sum    (row_mid)
   );

   lap3_cell u_cell_lower (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (s1_done),
      .center_row (1'b0),
      .tap_in     (s1_ff.pixel),
      .row_sum    (row_low)
   );

   always_comb begin
      lap = row_up + row_mid + row_low;
      if (lap < 0) begin
         lap_clamped = '0;
      end else if (lap > $signed((POS_W+1)'(255))) begin
         lap_clamped = '1;
      end else begin
         lap_clamped = lap[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_done) begin
         rsp_valid_ff <= s1_ff.produce;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_done) begin
         rsp_value_ff <= lap_clamped;
         rsp_row_ff   <= s1_ff.out_row;
         rsp_col_ff   <= s1_ff.out_col;
         rsp_last_ff  <= s1_ff.last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_out_row        = rsp_row_ff;
   assign rsp_out_col        = rsp_col_ff;
   assign rsp_frame_last     = rsp_last_ff;

endmodule

/* rtl/lap3_ram.sv */
// ----------------------------------------------------------------------------
// lap3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lap3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lap3_cell.sv */
// ----------------------------------------------------------------------------
// lap3_cell
// One window row: two pixel registers shifted by the incoming sample. The
// row adds its three taps and, for the center row, takes nine times the
// middle tap off that sum.
// ----------------------------------------------------------------------------
module lap3_cell
   import lap3_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift_en,
   input  logic                    center_row,
   input  logic [PIX_W-1:0]        tap_in,
   output logic signed [POS_W:0]   row_sum
);

   logic [PIX_W-1:0]  old_ff;
   logic [PIX_W-1:0]  new_ff;
   logic [SUM3_W-1:0] sum3;
   logic [POS_W-1:0]  mid9;
   logic [POS_W:0]    center_term;

   always_ff @(posedge clock) begin
      if (reset) begin
         old_ff <= '0;
         new_ff <= '0;
      end else if (shift_en) begin
         old_ff <= new_ff;
         new_ff <= tap_in;
      end
   end

   assign sum3        = SUM3_W'(old_ff) + SUM3_W'(new_ff) + SUM3_W'(tap_in);
   assign mid9        = (POS_W'(new_ff) << 3) + POS_W'(new_ff);
   assign center_term = center_row ? {1'b0, mid9} : '0;
   assign row_sum     = $signed((POS_W+1)'(sum3)) - $signed(center_term);

endmodule

/* tb/laplacian_3x3_convolution_checker.sv */
// ----------------------------------------------------------------------------
// laplacian_3x3_convolution_checker
// Watches the pixel, result and register channels of the Laplacian core.
// Every pixel transfer is run through a raster model with its own line
// stores, window and counters; the filtered pixels that model produces are
// queued and matched in order, field by field, against each result transfer.
// ----------------------------------------------------------------------------
module laplacian_3x3_convolution_checker
   import lap3_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             req_frame_start,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [PIX_W-1:0] rsp_filtered_value,
   input  logic [POS_W-1:0] rsp_out_row,
   input  logic [POS_W-1:0] rsp_out_col,
   input  logic             rsp_frame_last,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output int unsigned      pixels_seen,
   output int unsigned      results_seen,
   output int unsigned      pending,
   output int unsigned      failures
);

   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } filtered_pixel_type;

   logic [CFG_W-1:0]   width_reg;
   logic [CFG_W-1:0]   height_reg;
   logic [PIX_W-1:0]   upper_line [MAX_WIDTH];
   logic [PIX_W-1:0]   middle_line [MAX_WIDTH];
   logic [PIX_W-1:0]   win [6];
   int unsigned        row_pos;
   int unsigned        col_pos;
   filtered_pixel_type filtered_q [$];

   function automatic bit filter_pixel(input logic [PIX_W-1:0] px, input logic start,
                                       output filtered_pixel_type res);
      int unsigned      w;
      int unsigned      h;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      int               lap;
      bit               hit;
      w = (width_reg < MIN_SIZE) ? MIN_SIZE :
          (width_reg > MAX_WIDTH_VAL) ? MAX_WIDTH_VAL : width_reg;
      h = (height_reg < MIN_SIZE) ? MIN_SIZE :
          (height_reg > MAX_HEIGHT_VAL) ? MAX_HEIGHT_VAL : height_reg;
      if (start) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) begin
         row_pos = 0;
      end
      up  = upper_line[col_pos];
      mid = middle_line[col_pos];
      hit = (row_pos >= 2) && (col_pos >= 2);
      res = '0;
      if (hit) begin
         lap = int'(win[0]) + int'(win[1]) + int'(up) + int'(win[2]) + int'(mid)
             + int'(win[4]) + int'(win[5]) + int'(px) - 8 * int'(win[3]);
         if (lap < 0) begin
            lap = 0;
         end else if (lap > 255) begin
            lap = 255;
         end
         res.value = PIX_W'(lap);
         res.row   = POS_W'(row_pos - 1);
         res.col   = POS_W'(col_pos - 1);
         res.last  = (row_pos == h - 1) && (col_pos == w - 1);
      end
      win[0] = win[1];
      win[1] = up;
      win[2] = win[3];
      win[3] = mid;
      win[4] = win[5];
      win[5] = px;
      upper_line[col_pos]  = mid;
      middle_line[col_pos] = px;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) begin
            row_pos = 0;
         end
      end
      return hit;
   endfunction

   always @(posedge clock) begin : monitor
      filtered_pixel_type got;
      filtered_pixel_type want;
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         row_pos    = 0;
         col_pos    = 0;
         foreach (win[i]) win[i] = '0;
         foreach (upper_line[i]) upper_line[i] = '0;
         foreach (middle_line[i]) middle_line[i] = '0;
         filtered_q.delete();
         pixels_seen  = 0;
         results_seen = 0;
         pending      = 0;
         failures     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            got.value = rsp_filtered_value;
            got.row   = rsp_out_row;
            got.col   = rsp_out_col;
            got.last  = rsp_frame_last;
            if (filtered_q.size() == 0) begin
               $error("unexpected result transfer: row %0d, col %0d, value %0d",
                      got.row, got.col, got.value);
               failures++;
            end else begin
               want = filtered_q.pop_front();
               if (got.value !== want.value) begin
                  $error("filtered_value: expected %0d, actual %0d", want.value, got.value);
                  failures++;
               end
               if (got.row !== want.row) begin
                  $error("out_row: expected %0d, actual %0d", want.row, got.row);
                  failures++;
               end
               if (got.col !== want.col) begin
                  $error("out_col: expected %0d, actual %0d", want.col, got.col);
                  failures++;
               end
               if (got.last !== want.last) begin
                  $error("frame_last: expected %0d, actual %0d", want.last, got.last);
                  failures++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH) begin
               width_reg = csr_wdata;
            end else begin
               height_reg = csr_wdata;
            end
         end
         if (req_valid && req_ready) begin
            pixels_seen++;
            if (filter_pixel(req_pixel, req_frame_start, want)) begin
               filtered_q = {filtered_q, want};
            end
         end
         pending = filtered_q.size();
      end
   end

endmodule

/* tb/laplacian_3x3_convolution_core_tb.sv */
// ----------------------------------------------------------------------------
// laplacian_3x3_convolution_core_tb
// Streams raster pixel frames into the Laplacian core and lets the checker
// score every filtered pixel. A few hand-built 3x3 frames hit both clamp
// limits and counter wrap; random phases then mix sizes, including
// out-of-range sizes and frames that narrow without a start mark, with
// well-formed, broken and noisy frames under changing backpressure and one
// long output hold-off. A wider frame always opens with a start mark.
// ----------------------------------------------------------------------------
module laplacian_3x3_convolution_core_tb;
   import lap3_pkg::*;

   localparam int unsigned RANDOM_ITEMS    = 1550;
   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned PHASE_CAP       = 150;
   localparam longint      RUN_LIMIT       = 10_000_000;

   typedef enum int unsigned {
      STYLE_RANDOM,
      STYLE_EXTREME,
      STYLE_FLAT
   } pixel_style_type;

   logic             clock           = 1'b0;
   logic             reset           = 1'b1;
   logic             req_valid       = 1'b0;
   logic             req_ready;
   logic [PIX_W-1:0] req_pixel       = '0;
   logic             req_frame_start = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready       = 1'b0;
   logic [PIX_W-1:0] rsp_filtered_value;
   logic [POS_W-1:0] rsp_out_row;
   logic [POS_W-1:0] rsp_out_col;
   logic             rsp_frame_last;
   logic             csr_valid       = 1'b0;
   logic             csr_ready;
   logic             csr_index       = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0] csr_wdata       = '0;

   int unsigned pixels_seen;
   int unsigned results_seen;
   int unsigned pending;
   int unsigned failures;

   int unsigned items_sent    = 0;
   int unsigned random_items  = 0;
   int unsigned size_settings = 0;
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_idle_pct  = 0;
   int unsigned cur_w         = 3;
   logic        squeeze_armed = 1'b0;
   bit          squeeze_done  = 1'b0;

   laplacian_3x3_convolution_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel          (req_pixel),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_frame_last     (rsp_frame_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   laplacian_3x3_convolution_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel          (req_pixel),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_frame_last     (rsp_frame_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .pixels_seen        (pixels_seen),
      .results_seen       (results_seen),
      .pending            (pending),
      .failures           (failures)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT);
      $display("FAIL laplacian_3x3_convolution_core");
      $finish;
   end

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (squeeze_armed && !squeeze_done) begin
            squeeze_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid       <= 1'b1;
      req_pixel       <= px;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_frame(input int unsigned len, input bit with_start, input bit noisy);
      pixel_style_type  style;
      int unsigned      base;
      logic [PIX_W-1:0] px;
      logic             fs;
      style = pixel_style_type'($urandom_range(0, 2));
      base  = $urandom_range(0, 252);
      for (int unsigned i = 0; i < len; i++) begin
         case (style)
            STYLE_RANDOM:  px = PIX_W'($urandom_range(0, 255));
            STYLE_EXTREME: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:       px = PIX_W'(base + $urandom_range(0, 3));
         endcase
         fs = noisy ? 1'($urandom_range(0, 1)) : (with_start && i == 0);
         send_pixel(px, fs);
      end
   endtask

   task automatic write_sizes(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
      csr_valid <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= wv;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= hv;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_settings++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      wait (pixels_seen == items_sent && pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CFG_W-1:0] pick_size(input int unsigned small_max);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return CFG_W'($urandom_range(3, small_max));
      end else if (roll < 80) begin
         return CFG_W'($urandom_range(0, 2));
      end else if (roll < 90) begin
         return CFG_W'($urandom_range(4097, 8191));
      end
      return CFG_W'($urandom());
   endfunction

   function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v);
      return (v < MIN_SIZE) ? MIN_SIZE : (v > MAX_WIDTH_VAL) ? MAX_WIDTH_VAL : v;
   endfunction

   task automatic run_phase();
      logic [CFG_W-1:0] wv;
      logic [CFG_W-1:0] hv;
      int unsigned      w;
      int unsigned      h;
      int unsigned      len;
      int unsigned      roll;
      int unsigned      frames;
      bit               with_start;
      bit               noisy;
      bit               must_start;
      settle();
      wv = pick_size(12);
      hv = pick_size(8);
      write_sizes(wv, hv);
      w          = clamp_size(wv);
      h          = clamp_size(hv);
      must_start = (w > cur_w);
      with_start = must_start || ($urandom_range(0, 4) != 0);
      frames     = $urandom_range(1, 3);
      repeat (frames) begin
         roll  = $urandom_range(0, 99);
         noisy = 1'b0;
         len   = w * h;
         if (len > PHASE_CAP) begin
            len = $urandom_range(50, PHASE_CAP);
         end
         if (roll >= 95 && !must_start) begin
            noisy      = 1'b1;
            with_start = 1'b0;
            len        = $urandom_range(1, 20);
         end else if (roll >= 85) begin
            with_start = 1'b1;
            len        = $urandom_range(1, len - 1);
         end else if (roll >= 75 && !must_start) begin
            with_start = 1'b0;
         end
         send_frame(len, with_start, noisy);
         random_items += len;
         with_start = 1'b1;
         must_start = 1'b0;
      end
      cur_w = w;
   endtask

   initial begin : stimulus
      logic [PIX_W-1:0] probe_px [27] = '{
         8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
         8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
         8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd200
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 32;
      rsp_idle_pct = 65;
      // The second 3x3 frame has no start mark and relies on the counters wrapping.
      write_sizes(CFG_W'(3), CFG_W'(3));
      cur_w = 3;
      for (int unsigned i = 0; i < 27; i++) begin
         send_pixel(probe_px[i], (i == 0) || (i == 18));
      end

      while (random_items < RANDOM_ITEMS / 3) run_phase();

      req_idle_pct = 65;
      rsp_idle_pct = 32;
      while (random_items < 2 * RANDOM_ITEMS / 3) run_phase();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      settle();
      squeeze_armed <= 1'b1;
      write_sizes(CFG_W'(3), CFG_W'(5));
      cur_w = 3;
      repeat (4) begin
         send_frame(15, 1'b1, 1'b0);
         random_items += 15;
      end
      while (random_items < RANDOM_ITEMS) run_phase();

      settle();
      $display("Run covered %0d pixel transfers and %0d filtered results over %0d size settings,",
               pixels_seen, results_seen, size_settings);
      $display("with out-of-range sizes, broken frames and a %0d-cycle output hold-off.",
               HOLD_OFF_CYCLES);
      if (failures == 0) begin
         $display("PASS laplacian_3x3_convolution_core");
      end else begin
         $display("FAIL laplacian_3x3_convolution_core");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/lap3_pkg.sv
rtl/lap3_ram.sv
rtl/lap3_cell.sv
rtl/laplacian_3x3_convolution_core.sv
tb/laplacian_3x3_convolution_checker.sv
tb/laplacian_3x3_convolution_core_tb.sv
